@@ sv/gtcfr_pkg.sv @@
// shared types, codes and the crc-16 byte update for the gap-timed frame receiver
// no dependencies; imported by the receiver and its checker

package gtcfr_pkg;

	localparam int ADDR_W = 16;
	localparam int BYTE_W = 8;
	localparam int CRC_W  = 16;

	localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;
	localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
	localparam logic [BYTE_W-1:0] VERSION_ONE = 8'h01;
	localparam logic [BYTE_W-1:0] GAP_SAT     = 8'd255;

	localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 16'd0;
	localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd165;
	localparam logic [BYTE_W-1:0] GAP_LIMIT_RST   = 8'd6;
	localparam logic [BYTE_W-1:0] FRAME_LIMIT_RST = 8'd64;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_VERSION = 2'd1,
		PH_LENGTH  = 2'd2,
		PH_BODY    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		VERDICT_OK        = 2'd0,
		VERDICT_MISMATCH  = 2'd1,
		VERDICT_BAD_VER   = 2'd2,
		VERDICT_MALFORMED = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		REG_OWN_ADDRESS = 2'd0,
		REG_START_BYTE  = 2'd1,
		REG_GAP_LIMIT   = 2'd2,
		REG_FRAME_LIMIT = 2'd3
	} cfg_reg_t;

	// reflected crc-16, one byte folded in over eight bit steps
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else c = c >> 1;
		end
		return c;
	endfunction

endpackage

@@ sv/gap_timed_crc_frame_receiver.sv @@
// Gap-timed framed packet receiver with CRC-16/MODBUS check over the data bytes.
// Takes one request per clock (a received byte or a timer tick); each byte
// request updates the frame state in the same cycle and, where it yields a body
// byte, loads the output register, so the result is shown the cycle after the
// request is taken. in_ready is low only while the output register holds a
// result that is not taken in that cycle. Configuration writes are always taken.
// depends on gtcfr_pkg

module gap_timed_crc_frame_receiver
	import gtcfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [BYTE_W-1:0]   rx_byte,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   body_byte,
	output logic [BYTE_W-1:0]   body_index,
	output logic                is_last,
	output logic [1:0]          verdict,
	output logic [BYTE_W-1:0]   frame_length,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [ADDR_W-1:0]   cfg_data
);

	// configuration registers
	logic [ADDR_W-1:0] own_address_q;
	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] gap_limit_q;
	logic [BYTE_W-1:0] frame_limit_q;

	// frame state
	phase_t            phase_q, phase_d, ph_eff;
	logic [BYTE_W-1:0] body_count_q, body_count_d, cnt_eff;
	logic [BYTE_W-1:0] body_length_q, body_length_d;
	logic              version_good_q, version_good_d;
	logic [CRC_W-1:0]  running_crc_q, running_crc_d;
	logic [ADDR_W-1:0] seen_address_q, seen_address_d;
	logic [BYTE_W-1:0] crc_low_q, crc_low_d;
	logic [BYTE_W-1:0] gap_count_q;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] body_byte_q, body_index_q, frame_length_q;
	logic              is_last_q;
	verdict_t          verdict_q;

	logic              emit;
	logic [BYTE_W-1:0] emit_byte, emit_index, emit_len;
	logic              emit_last;
	verdict_t          emit_verdict;

	logic              accept, byte_req, gap_drop;
	logic [BYTE_W:0]   len9, idx_p1, idx_p2;
	logic              oversize, last_body;
	logic [CRC_W-1:0]  rx_crc;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign byte_req  = accept && !func;
	assign cfg_ready = 1'b1;

	assign gap_drop = gap_count_q > gap_limit_q;
	assign ph_eff   = gap_drop ? PH_HUNT : phase_q;
	assign cnt_eff  = gap_drop ? '0 : body_count_q;

	assign len9      = {1'b0, body_length_q};
	assign idx_p1    = {1'b0, cnt_eff} + 9'd1;
	assign idx_p2    = {1'b0, cnt_eff} + 9'd2;
	assign oversize  = (len9 + 9'd3) > {1'b0, frame_limit_q};
	assign last_body = idx_p1 >= len9;

	// next phase
	always_comb begin
		phase_d = ph_eff;
		case (ph_eff)
			PH_HUNT:    if (rx_byte == start_byte_q) phase_d = PH_VERSION;
			PH_VERSION: phase_d = PH_LENGTH;
			PH_LENGTH:  phase_d = (rx_byte == '0) ? PH_HUNT : PH_BODY;
			PH_BODY:    if (!oversize && last_body) phase_d = PH_HUNT;
			default:    phase_d = PH_HUNT;
		endcase
	end

	// datapath and result
	always_comb begin
		body_count_d   = cnt_eff;
		body_length_d  = body_length_q;
		version_good_d = version_good_q;
		running_crc_d  = running_crc_q;
		seen_address_d = seen_address_q;
		crc_low_d      = crc_low_q;
		emit           = 1'b0;
		emit_byte      = rx_byte;
		emit_index     = cnt_eff;
		emit_last      = 1'b0;
		emit_verdict   = VERDICT_OK;
		emit_len       = '0;
		rx_crc         = {rx_byte, crc_low_q};
		case (ph_eff)
			PH_HUNT: ;
			PH_VERSION: version_good_d = (rx_byte == VERSION_ONE);
			PH_LENGTH: begin
				body_length_d  = rx_byte;
				body_count_d   = '0;
				running_crc_d  = CRC_INIT;
				seen_address_d = '0;
				crc_low_d      = '0;
				if (rx_byte == '0) begin
					// empty body: verdict on the length byte itself
					emit         = 1'b1;
					emit_byte    = '0;
					emit_index   = '0;
					emit_last    = 1'b1;
					emit_verdict = version_good_q ? VERDICT_MALFORMED : VERDICT_BAD_VER;
				end
			end
			PH_BODY: begin
				if (!oversize) begin
					if (cnt_eff == 8'd0) seen_address_d[7:0] = rx_byte;
					else if (cnt_eff == 8'd1) seen_address_d[15:8] = rx_byte;
					else if (idx_p2 < len9) running_crc_d = crc_byte(running_crc_q, rx_byte);
					if (idx_p2 == len9) crc_low_d = rx_byte;
					rx_crc = {rx_byte, crc_low_d};
					emit = 1'b1;
					if (last_body) begin
						emit_last = 1'b1;
						emit_len  = body_length_q;
						if (!version_good_q) emit_verdict = VERDICT_BAD_VER;
						else if (len9 < 9'd4) emit_verdict = VERDICT_MALFORMED;
						else if (rx_crc != running_crc_d || seen_address_d != own_address_q)
							emit_verdict = VERDICT_MISMATCH;
						else emit_verdict = VERDICT_OK;
						body_count_d = '0;
					end else begin
						body_count_d = idx_p1[BYTE_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= OWN_ADDRESS_RST;
			start_byte_q  <= START_BYTE_RST;
			gap_limit_q   <= GAP_LIMIT_RST;
			frame_limit_q <= FRAME_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_OWN_ADDRESS: own_address_q <= cfg_data;
				REG_START_BYTE:  start_byte_q  <= cfg_data[BYTE_W-1:0];
				REG_GAP_LIMIT:   gap_limit_q   <= cfg_data[BYTE_W-1:0];
				REG_FRAME_LIMIT: frame_limit_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			body_count_q   <= '0;
			body_length_q  <= '0;
			version_good_q <= 1'b0;
			running_crc_q  <= CRC_INIT;
			seen_address_q <= '0;
			crc_low_q      <= '0;
			gap_count_q    <= '0;
		end else if (accept) begin
			if (func) begin
				if (gap_count_q != GAP_SAT) gap_count_q <= gap_count_q + 8'd1;
			end else begin
				phase_q        <= phase_d;
				body_count_q   <= body_count_d;
				body_length_q  <= body_length_d;
				version_good_q <= version_good_d;
				running_crc_q  <= running_crc_d;
				seen_address_q <= seen_address_d;
				crc_low_q      <= crc_low_d;
				gap_count_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= byte_req && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_req && emit) begin
			body_byte_q    <= emit_byte;
			body_index_q   <= emit_index;
			is_last_q      <= emit_last;
			verdict_q      <= emit_verdict;
			frame_length_q <= emit_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign body_byte    = body_byte_q;
	assign body_index   = body_index_q;
	assign is_last      = is_last_q;
	assign verdict      = verdict_q;
	assign frame_length = frame_length_q;

endmodule

@@ sv/gtcfr_checker.sv @@
// port-level checks for the gap-timed frame receiver, bound to its top level
// depends on gtcfr_pkg and gap_timed_crc_frame_receiver

module gtcfr_checker
	import gtcfr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              func,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] body_byte,
	input logic [BYTE_W-1:0] body_index,
	input logic              is_last,
	input logic [1:0]        verdict,
	input logic [BYTE_W-1:0] frame_length
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(body_byte)
			&& $stable(body_index) && $stable(is_last) && $stable(verdict))
		else $error("result changed while stalled");

	// verdict and length only ride on the last body byte
	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> verdict == VERDICT_OK && frame_length == '0)
		else $error("verdict or length on a middle byte");

	// empty body reports only bad version or malformed
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last && frame_length == '0 |-> body_index == '0
			&& (verdict == VERDICT_BAD_VER || verdict == VERDICT_MALFORMED))
		else $error("bad result for empty body");

	// last byte sits at the end of the body
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last && frame_length != '0 |-> body_index == frame_length - 8'd1)
		else $error("last byte not at end of body");

	// a new result follows a taken request
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && !func))
		else $error("result without a byte request");

endmodule

bind gap_timed_crc_frame_receiver gtcfr_checker u_gtcfr_checker (.*);

@@ verif/testbench.sv @@
// self-checking testbench for gap_timed_crc_frame_receiver: a queued request driver,
// a result monitor and a frame predictor checked byte by byte
// depends on gtcfr_pkg and the receiver rtl
`timescale 1ns / 100ps

module testbench;
	import gtcfr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int CHUNK_ITEMS = 62;
	localparam int MAX_PRINTED = 200;

	typedef struct packed {
		logic              f;
		logic [BYTE_W-1:0] b;
	} rx_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] body_byte;
		logic [BYTE_W-1:0] idx;
		logic              last;
		verdict_t          verdict;
		logic [BYTE_W-1:0] length;
	} body_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              func = 1'b0;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_ready = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;

	logic              in_ready;
	logic              out_valid;
	logic [BYTE_W-1:0] body_byte;
	logic [BYTE_W-1:0] body_index;
	logic              is_last;
	logic [1:0]        verdict;
	logic [BYTE_W-1:0] frame_length;
	logic              cfg_ready;

	gap_timed_crc_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.body_byte    (body_byte),
		.body_index   (body_index),
		.is_last      (is_last),
		.verdict      (verdict),
		.frame_length (frame_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rx_req_t   pending_q[$];
	body_res_t expected_body_q[$];
	rx_req_t   next_req;
	body_res_t want_res;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int result_num = 0;
	int cycle_count = 0;
	int chunk_items = 0;
	bit need_resync = 1'b0;

	// predictor copy of the registers
	logic [ADDR_W-1:0] reg_own_addr = OWN_ADDRESS_RST;
	logic [BYTE_W-1:0] reg_start = START_BYTE_RST;
	logic [BYTE_W-1:0] reg_gap_limit = GAP_LIMIT_RST;
	logic [BYTE_W-1:0] reg_frame_limit = FRAME_LIMIT_RST;

	// predictor copy of the frame state
	phase_t            fr_phase = PH_HUNT;
	logic [BYTE_W-1:0] fr_count = '0;
	logic [BYTE_W-1:0] fr_len = '0;
	logic              fr_ver_ok = 1'b0;
	logic [CRC_W-1:0]  fr_crc = CRC_INIT;
	logic [ADDR_W-1:0] fr_addr = '0;
	logic [BYTE_W-1:0] fr_crc_lo = '0;
	logic [BYTE_W-1:0] fr_gap = '0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [CRC_W-1:0] modbus_crc_step(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] d);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, d};
		repeat (BYTE_W) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic note_error(input string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			note_error($sformatf("result %0d %s got 0x%0h want 0x%0h", result_num, name,
				got, want));
	endtask

	// works out the body byte (if any) that one accepted request yields
	task automatic track_request(input logic f, input logic [BYTE_W-1:0] b);
		body_res_t r;
		verdict_t  v;
		int        i;
		int        len;
		if (f) begin
			if (fr_gap != GAP_SAT) fr_gap = fr_gap + 8'd1;
		end else begin
			if (fr_gap > reg_gap_limit) begin
				fr_phase = PH_HUNT;
				fr_count = '0;
			end
			fr_gap = '0;
			case (fr_phase)
				PH_HUNT: begin
					if (b == reg_start) fr_phase = PH_VERSION;
				end
				PH_VERSION: begin
					fr_ver_ok = (b == VERSION_ONE);
					fr_phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					fr_len = b;
					fr_count = '0;
					fr_crc = CRC_INIT;
					fr_addr = '0;
					fr_crc_lo = '0;
					if (b == 8'h00) begin
						v = fr_ver_ok ? VERDICT_MALFORMED : VERDICT_BAD_VER;
						r = '{8'h00, 8'h00, 1'b1, v, 8'h00};
						expected_body_q.push_back(r);
						fr_phase = PH_HUNT;
					end else begin
						fr_phase = PH_BODY;
					end
				end
				PH_BODY: begin
					i = int'(fr_count);
					len = int'(fr_len);
					// oversize frames are swallowed until a gap
					if (3 + len <= int'(reg_frame_limit)) begin
						if (i == 0) fr_addr[7:0] = b;
						else if (i == 1) fr_addr[15:8] = b;
						else if (i + 2 < len) fr_crc = modbus_crc_step(fr_crc, b);
						if (i + 2 == len) fr_crc_lo = b;
						if (i + 1 >= len) begin
							if (!fr_ver_ok) v = VERDICT_BAD_VER;
							else if (len < 4) v = VERDICT_MALFORMED;
							else if ({b, fr_crc_lo} != fr_crc || fr_addr != reg_own_addr)
								v = VERDICT_MISMATCH;
							else v = VERDICT_OK;
							r = '{b, i[7:0], 1'b1, v, fr_len};
							expected_body_q.push_back(r);
							fr_phase = PH_HUNT;
							fr_count = '0;
						end else begin
							r = '{b, i[7:0], 1'b0, VERDICT_OK, 8'h00};
							expected_body_q.push_back(r);
							fr_count = i[7:0] + 8'd1;
						end
					end
				end
				default: fr_phase = PH_HUNT;
			endcase
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) track_request(func, rx_byte);
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_q.pop_front();
					in_valid <= 1'b1;
					func <= next_req.f;
					rx_byte <= next_req.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				result_num++;
				if (expected_body_q.size() == 0) begin
					note_error($sformatf("result %0d with nothing expected", result_num));
				end else begin
					want_res = expected_body_q.pop_front();
					check_field("body_byte", int'(body_byte), int'(want_res.body_byte));
					check_field("body_index", int'(body_index), int'(want_res.idx));
					check_field("is_last", int'(is_last), int'(want_res.last));
					check_field("verdict", int'(verdict), int'(want_res.verdict));
					check_field("frame_length", int'(frame_length), int'(want_res.length));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_req(input logic f, input logic [BYTE_W-1:0] b);
		rx_req_t q;
		q = '{f, b};
		pending_q.push_back(q);
		chunk_items++;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		push_req(1'b0, b);
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_req(1'b1, 8'($urandom_range(255)));
	endtask

	// ticks between two bytes, never beyond the gap limit
	task automatic push_spacing();
		int cap;
		cap = (reg_gap_limit < 3) ? int'(reg_gap_limit) : 3;
		if (cap != 0 && $urandom_range(99) >= 70) push_ticks($urandom_range(cap, 1));
	endtask

	// a gap followed by a byte that cannot open a frame leaves the block hunting
	task automatic force_hunt();
		if (reg_gap_limit != GAP_SAT) begin
			push_ticks(int'(reg_gap_limit) + 1);
			push_byte(reg_start ^ 8'h01);
		end
		need_resync = 1'b0;
	endtask

	task automatic send_frame();
		logic [BYTE_W-1:0] seq[$];
		logic [BYTE_W-1:0] d;
		logic [CRC_W-1:0]  crc;
		logic [ADDR_W-1:0] addr;
		bit                oversize;
		int                pick;
		int                len;
		int                maxlen;
		int                cap;
		int                cut;
		pick = $urandom_range(99);
		maxlen = int'(reg_frame_limit) - 3;
		oversize = 1'b0;
		if (pick < 6) begin
			len = 0;
		end else if (pick < 12) begin
			len = $urandom_range(3, 1);
		end else if (pick < 18 && reg_gap_limit != GAP_SAT) begin
			cap = (maxlen + 6 > 255) ? 255 : maxlen + 6;
			len = $urandom_range(cap, maxlen + 1);
			oversize = 1'b1;
		end else begin
			cap = (maxlen < 14) ? maxlen : 14;
			len = $urandom_range(cap, 4);
		end
		seq.push_back(reg_start);
		if ($urandom_range(99) < 8) seq.push_back(8'($urandom_range(255)));
		else seq.push_back(VERSION_ONE);
		seq.push_back(len[7:0]);
		if (len >= 4 && !oversize) begin
			addr = ($urandom_range(99) < 80) ? reg_own_addr : 16'($urandom_range(65535));
			seq.push_back(addr[7:0]);
			seq.push_back(addr[15:8]);
			crc = CRC_INIT;
			for (int k = 0; k < len - 4; k++) begin
				case ($urandom_range(5))
					0: d = 8'h00;
					1: d = 8'hFF;
					default: d = 8'($urandom_range(255));
				endcase
				crc = modbus_crc_step(crc, d);
				seq.push_back(d);
			end
			if ($urandom_range(99) < 12) crc = crc ^ (16'h0001 << $urandom_range(15));
			seq.push_back(crc[7:0]);
			seq.push_back(crc[15:8]);
		end else begin
			for (int k = 0; k < len; k++) seq.push_back(8'($urandom_range(255)));
		end
		cut = seq.size();
		if (reg_gap_limit != GAP_SAT && $urandom_range(99) < 5)
			cut = $urandom_range(seq.size() - 1, 1);
		if (need_resync) force_hunt();
		for (int k = 0; k < cut; k++) begin
			if (k > 0) push_spacing();
			push_byte(seq[k]);
		end
		if (cut < seq.size()) push_ticks(int'(reg_gap_limit) + 1);
		else if (oversize) need_resync = 1'b1;
	endtask

	task automatic send_noise();
		logic [BYTE_W-1:0] b;
		repeat ($urandom_range(4, 1)) begin
			b = 8'($urandom_range(255));
			if ($urandom_range(1)) begin
				push_req(1'b1, b);
			end else begin
				// with no gap detection a stray start byte would never be dropped
				if (reg_gap_limit == GAP_SAT && b == reg_start) b = b ^ 8'h01;
				push_byte(b);
			end
		end
		if (reg_gap_limit != GAP_SAT) need_resync = 1'b1;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_q.size() != 0 || in_valid || expected_body_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_chunk(input int sidle, input int rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		chunk_items = 0;
		while (chunk_items < CHUNK_ITEMS) begin
			if ($urandom_range(99) < 8) send_noise();
			else send_frame();
		end
		drain();
	endtask

	task automatic run_phase();
		run_chunk(0, 0);
		run_chunk(56, 0);
		run_chunk(0, 56);
		run_chunk(13, 13);
		force_hunt();
		drain();
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [ADDR_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_OWN_ADDRESS: reg_own_addr = val;
			REG_START_BYTE: reg_start = val[7:0];
			REG_GAP_LIMIT: reg_gap_limit = val[7:0];
			REG_FRAME_LIMIT: reg_frame_limit = val[7:0];
			default: ;
		endcase
	endtask

	// upper data bits of the byte-wide registers carry junk to check masking
	task automatic write_config(input logic [ADDR_W-1:0] own, input logic [BYTE_W-1:0] sb,
		input logic [BYTE_W-1:0] gl, input logic [BYTE_W-1:0] fl);
		write_reg(REG_OWN_ADDRESS, own);
		write_reg(REG_START_BYTE, {8'($urandom_range(255)), sb});
		write_reg(REG_GAP_LIMIT, {8'($urandom_range(255)), gl});
		write_reg(REG_FRAME_LIMIT, {8'($urandom_range(255)), fl});
		@(negedge clk);
	endtask

	// longest body the frame limit allows, with a tick run that saturates the gap counter
	task automatic send_long_frame();
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] d;
		crc = CRC_INIT;
		push_byte(reg_start);
		push_byte(VERSION_ONE);
		push_byte(8'd252);
		push_byte(reg_own_addr[7:0]);
		push_byte(reg_own_addr[15:8]);
		for (int k = 0; k < 248; k++) begin
			d = 8'($urandom_range(255));
			crc = modbus_crc_step(crc, d);
			if (k == 100) push_ticks(260);
			push_byte(d);
		end
		push_byte(crc[7:0]);
		push_byte(crc[15:8]);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed frames under the reset register values
		push_byte(START_BYTE_RST); push_byte(8'h00); push_byte(8'h00);
		push_byte(START_BYTE_RST); push_byte(VERSION_ONE); push_byte(8'h00);
		push_byte(START_BYTE_RST); push_byte(VERSION_ONE); push_byte(8'h02);
		push_byte(8'h11); push_byte(8'h22);
		push_byte(START_BYTE_RST); push_byte(VERSION_ONE); push_byte(8'h04);
		push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF); push_byte(8'hFF);
		// frame cut short by a gap just over the limit
		push_byte(START_BYTE_RST); push_byte(VERSION_ONE);
		push_ticks(int'(GAP_LIMIT_RST) + 1);
		push_byte(8'h00);
		force_hunt();
		drain();

		write_config(16'hFFFF, 8'h00, 8'h00, 8'd8);
		run_phase();

		write_config(16'($urandom_range(65535)), 8'hFF, 8'd255, 8'd255);
		send_long_frame();
		drain();
		run_phase();

		repeat (3) begin
			write_config(16'($urandom_range(65535)), 8'($urandom_range(255)),
				8'($urandom_range(12, 1)), 8'($urandom_range(255, 8)));
			run_phase();
		end

		drain();
		repeat (10) @(negedge clk);
		if (expected_body_q.size() != 0)
			note_error($sformatf("%0d results never arrived", expected_body_q.size()));
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
